// ===== sv/dgd_pkg.sv =====
// Shared widths, register codes, config bundle and lookup functions for the gradient ditherer.
package dgd_pkg;

  localparam int unsigned ColW      = 24;  // 0xRRGGBB
  localparam int unsigned DimW      = 11;  // area size registers
  localparam int unsigned PixW      = 10;  // pixel coordinates
  localparam int unsigned DivW      = 12;  // span divisor, up to 2*2047-2
  localparam int unsigned NumW      = 20;  // blend numerator, below 256*span
  localparam int unsigned ChW       = 8;   // one colour channel
  localparam int unsigned NumCh     = 3;   // red, green, blue
  localparam int unsigned BayW      = 4;   // Bayer threshold
  localparam int unsigned QuoW      = 8;   // blended channel
  localparam int unsigned DivStages = 4;   // divider pipeline depth
  localparam int unsigned LvlW      = 14;  // scaled level before /255
  localparam int unsigned QW        = 7;   // quantised level incl. headroom
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned BlendLat  = 3;
  localparam int unsigned QuantLat  = 2;
  localparam int unsigned Latency   = BlendLat + DivStages + QuantLat;

  localparam logic [QW-1:0] RbMax = QW'(31);
  localparam logic [QW-1:0] GMax  = QW'(63);

  typedef enum logic [CfgIdxW-1:0] {
    RegStartColor = 2'd0,
    RegEndColor   = 2'd1,
    RegAreaWidth  = 2'd2,
    RegAreaHeight = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ColW-1:0] start_color;
    logic [ColW-1:0] end_color;
    logic [DivW-1:0] span;
  } cfg_t;

  // 4x4 ordered-dither matrix, index = {y[1:0], x[1:0]}
  function automatic logic [BayW-1:0] bayer_lookup(input logic [3:0] idx);
    logic [BayW-1:0] v;
    case (idx)
      4'd0:    v = 4'd0;
      4'd1:    v = 4'd8;
      4'd2:    v = 4'd2;
      4'd3:    v = 4'd10;
      4'd4:    v = 4'd12;
      4'd5:    v = 4'd4;
      4'd6:    v = 4'd14;
      4'd7:    v = 4'd6;
      4'd8:    v = 4'd3;
      4'd9:    v = 4'd11;
      4'd10:   v = 4'd1;
      4'd11:   v = 4'd9;
      4'd12:   v = 4'd15;
      4'd13:   v = 4'd7;
      4'd14:   v = 4'd13;
      default: v = 4'd5;
    endcase
    return v;
  endfunction

  // floor((2b+1)*255/32): threshold offset after dropping the common factor 32
  function automatic logic [ChW-1:0] dither_bias(input logic [BayW-1:0] b);
    logic [12:0] k;
    k = 13'({b, 1'b1}) * 13'd255;
    return k[12:5];
  endfunction

  function automatic logic [QW-1:0] chan_max(input int unsigned ch);
    return (ch == 1) ? GMax : RbMax;
  endfunction

endpackage

// ===== sv/dgd_cfg.sv =====
// Configuration registers and span divisor derivation.
module dgd_cfg #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_i,
  input  logic [dgd_pkg::CfgIdxW-1:0]  index_i,
  input  logic [dgd_pkg::ColW-1:0]     data_i,
  output dgd_pkg::cfg_t                cfg_o
);

  logic [dgd_pkg::ColW-1:0] start_color_q, end_color_q;
  logic [dgd_pkg::DimW-1:0] area_width_q, area_height_q;
  logic [dgd_pkg::DimW-1:0] w_cl, h_cl;
  logic [dgd_pkg::DivW-1:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_color_q <= '0;
      end_color_q   <= '1;
      area_width_q  <= dgd_pkg::DimW'(1);
      area_height_q <= dgd_pkg::DimW'(1);
    end else if (wr_i) begin
      case (dgd_pkg::cfg_reg_e'(index_i))
        dgd_pkg::RegStartColor: start_color_q <= data_i;
        dgd_pkg::RegEndColor:   end_color_q   <= data_i;
        dgd_pkg::RegAreaWidth:  area_width_q  <= data_i[dgd_pkg::DimW-1:0];
        dgd_pkg::RegAreaHeight: area_height_q <= data_i[dgd_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [dgd_pkg::DimW-1:0] clamp_dim(input logic [dgd_pkg::DimW-1:0] v);
    logic [dgd_pkg::DimW-1:0] r;
    if (v == '0) begin
      r = dgd_pkg::DimW'(1);
    end else if ({2'b00, v} > 13'(MAX_DIM)) begin
      r = dgd_pkg::DimW'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    w_cl = clamp_dim(area_width_q);
    h_cl = clamp_dim(area_height_q);
    sum  = {1'b0, w_cl} + {1'b0, h_cl};
    cfg_o.start_color = start_color_q;
    cfg_o.end_color   = end_color_q;
    cfg_o.span        = (sum > dgd_pkg::DivW'(3)) ? sum - dgd_pkg::DivW'(2)
                                                  : dgd_pkg::DivW'(1);
  end

endmodule

// ===== sv/dgd_blend.sv =====
// Position clamp, Bayer pick and per-channel blend numerator (three stages).
module dgd_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [dgd_pkg::PixW-1:0]    pixel_x_i,
  input  logic [dgd_pkg::PixW-1:0]    pixel_y_i,
  input  dgd_pkg::cfg_t               cfg_i,
  output logic                        valid_o,
  output logic [dgd_pkg::BayW-1:0]    bayer_o,
  output logic [dgd_pkg::NumW-1:0]    num_o [dgd_pkg::NumCh]
);

  logic [dgd_pkg::PixW:0]   xy;
  logic [dgd_pkg::DivW-1:0] pos_d, pos_q, rest;
  logic [dgd_pkg::BayW-1:0] b1_q, b2_q, b3_q;
  logic                     v1_q, v2_q, v3_q;
  logic [dgd_pkg::NumW-1:0] ps_d [dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0] pe_d [dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0] ps_q [dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0] pe_q [dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0] num_q [dgd_pkg::NumCh];

  // stage 1: diagonal position, saturated at the span
  always_comb begin
    xy    = {1'b0, pixel_x_i} + {1'b0, pixel_y_i};
    pos_d = ({1'b0, xy} > cfg_i.span) ? cfg_i.span : {1'b0, xy};
  end

  // stage 2: s*(D-n) and e*n
  always_comb begin
    rest = cfg_i.span - pos_q;
    for (int c = 0; c < dgd_pkg::NumCh; c++) begin
      ps_d[c] = dgd_pkg::NumW'(cfg_i.start_color[dgd_pkg::ChW*(dgd_pkg::NumCh-1-c) +: dgd_pkg::ChW])
              * dgd_pkg::NumW'(rest);
      pe_d[c] = dgd_pkg::NumW'(cfg_i.end_color[dgd_pkg::ChW*(dgd_pkg::NumCh-1-c) +: dgd_pkg::ChW])
              * dgd_pkg::NumW'(pos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    b1_q  <= dgd_pkg::bayer_lookup({pixel_y_i[1:0], pixel_x_i[1:0]});
    b2_q  <= b1_q;
    b3_q  <= b2_q;
    for (int c = 0; c < dgd_pkg::NumCh; c++) begin
      ps_q[c]  <= ps_d[c];
      pe_q[c]  <= pe_d[c];
      num_q[c] <= ps_q[c] + pe_q[c];  // at most 255*D, fits
    end
  end

  assign valid_o = v3_q;
  assign bayer_o = b3_q;
  assign num_o   = num_q;

endmodule

// ===== sv/dgd_div.sv =====
// Pipelined restoring divider: numerator / span for all channels, two quotient bits a stage.
module dgd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [dgd_pkg::BayW-1:0]    bayer_i,
  input  logic [dgd_pkg::NumW-1:0]    num_i [dgd_pkg::NumCh],
  input  logic [dgd_pkg::DivW-1:0]    span_i,
  output logic                        valid_o,
  output logic [dgd_pkg::BayW-1:0]    bayer_o,
  output logic [dgd_pkg::QuoW-1:0]    quo_o [dgd_pkg::NumCh]
);

  localparam int unsigned Steps = dgd_pkg::QuoW / dgd_pkg::DivStages;
  localparam int unsigned Last  = dgd_pkg::DivStages - 1;

  logic                        v_q   [dgd_pkg::DivStages];
  logic [dgd_pkg::BayW-1:0]    b_q   [dgd_pkg::DivStages];
  logic [dgd_pkg::NumW-1:0]    rem_q [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic [dgd_pkg::QuoW-1:0]    quo_q [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0]    rem_d [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic [dgd_pkg::QuoW-1:0]    quo_d [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic [dgd_pkg::NumW-1:0]    rem_in [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic [dgd_pkg::QuoW-1:0]    quo_in [dgd_pkg::DivStages][dgd_pkg::NumCh];
  logic                        v_in  [dgd_pkg::DivStages];
  logic [dgd_pkg::BayW-1:0]    b_in  [dgd_pkg::DivStages];

  for (genvar s = 0; s < dgd_pkg::DivStages; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign v_in[s]   = valid_i;
      assign b_in[s]   = bayer_i;
      assign rem_in[s] = num_i;
      for (genvar c = 0; c < dgd_pkg::NumCh; c++) begin : g_ch
        assign quo_in[s][c] = '0;
      end
    end else begin : g_body
      assign v_in[s]   = v_q[s-1];
      assign b_in[s]   = b_q[s-1];
      assign rem_in[s] = rem_q[s-1];
      assign quo_in[s] = quo_q[s-1];
    end

    always_comb begin
      logic [dgd_pkg::NumW-1:0] r;
      logic [dgd_pkg::QuoW-1:0] q;
      logic [dgd_pkg::NumW-1:0] dsh;
      for (int c = 0; c < dgd_pkg::NumCh; c++) begin
        r = rem_in[s][c];
        q = quo_in[s][c];
        for (int k = 0; k < Steps; k++) begin
          dsh = dgd_pkg::NumW'(span_i) << (dgd_pkg::QuoW - 1 - Steps*s - k);
          if (r >= dsh) begin
            r = r - dsh;
            q[dgd_pkg::QuoW - 1 - Steps*s - k] = 1'b1;
          end
        end
        rem_d[s][c] = r;
        quo_d[s][c] = q;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      b_q[s]   <= b_in[s];
      rem_q[s] <= rem_d[s];
      quo_q[s] <= quo_d[s];
    end
  end

  assign valid_o = v_q[Last];
  assign bayer_o = b_q[Last];
  assign quo_o   = quo_q[Last];

  // every quotient bit resolved: the remainder left over is below the span
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[Last] |-> (rem_q[Last][0] < dgd_pkg::NumW'(span_i)) &&
                  (rem_q[Last][1] < dgd_pkg::NumW'(span_i)) &&
                  (rem_q[Last][2] < dgd_pkg::NumW'(span_i)))
    else $error("divider remainder not below span");

endmodule

// ===== sv/dgd_quant.sv =====
// Ordered-dither quantiser to 5/6/5 bits and RGB565 packing (two stages).
module dgd_quant (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [dgd_pkg::BayW-1:0]    bayer_i,
  input  logic [dgd_pkg::QuoW-1:0]    chan_i [dgd_pkg::NumCh],
  output logic                        valid_o,
  output logic [15:0]                 rgb565_o
);

  logic                     va_q, vb_q;
  logic [dgd_pkg::LvlW-1:0] lvl_d [dgd_pkg::NumCh];
  logic [dgd_pkg::LvlW-1:0] lvl_q [dgd_pkg::NumCh];
  logic [dgd_pkg::QW-1:0]   q_raw [dgd_pkg::NumCh];
  logic [dgd_pkg::QW-1:0]   q_cl  [dgd_pkg::NumCh];
  logic [15:0]              rgb_d, rgb_q;

  // stage A: c*M + floor((2B+1)*255/32)
  always_comb begin
    for (int c = 0; c < dgd_pkg::NumCh; c++) begin
      lvl_d[c] = dgd_pkg::LvlW'(chan_i[c]) * dgd_pkg::LvlW'(dgd_pkg::chan_max(c))
               + dgd_pkg::LvlW'(dgd_pkg::dither_bias(bayer_i));
    end
  end

  // stage B: /255 by reciprocal 257/65536, one-step correction, clamp
  always_comb begin
    logic [21:0]              prod;
    logic [dgd_pkg::QW-1:0]   q0;
    logic [dgd_pkg::LvlW-1:0] r;
    for (int c = 0; c < dgd_pkg::NumCh; c++) begin
      prod     = 22'(lvl_q[c]) + (22'(lvl_q[c]) << 8);
      q0       = dgd_pkg::QW'(prod[21:16]);
      r        = lvl_q[c] - ((dgd_pkg::LvlW'(q0) << 8) - dgd_pkg::LvlW'(q0));
      q_raw[c] = (r >= dgd_pkg::LvlW'(255)) ? q0 + dgd_pkg::QW'(1) : q0;
      q_cl[c]  = (q_raw[c] > dgd_pkg::chan_max(c)) ? dgd_pkg::chan_max(c) : q_raw[c];
    end
    rgb_d = {q_cl[0][4:0], q_cl[1][5:0], q_cl[2][4:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    rgb_q <= rgb_d;
  end

  assign valid_o  = vb_q;
  assign rgb565_o = rgb_q;

  // blended channel is at most 255, so the dithered level never needs the clamp
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va_q |-> (q_raw[0] <= dgd_pkg::RbMax) && (q_raw[1] <= dgd_pkg::GMax) &&
             (q_raw[2] <= dgd_pkg::RbMax))
    else $error("quantised level above channel maximum");

endmodule

// ===== sv/diagonal_gradient_dither_rgb565_unit.sv =====
// Top level of the diagonal two-colour gradient generator with 4x4 ordered dither to RGB565.
//
//  channel   | signals                                     | transfer when
//  ----------+---------------------------------------------+-----------------------------
//  pixel in  | start, busy, pixel_x_i, pixel_y_i           | start high, busy low
//  pixel out | valid_o, rgb565_o                           | valid_o high (one cycle)
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,      | cfg_valid_i and cfg_ready_o
//            | cfg_data_i                                  |
//
// Nine-stage pipeline taking one pixel per clock. Stages: position clamp,
// products, sum, four divider stages (two quotient bits each, the 8-bit
// quotient sets the depth), dither scale, /255. busy never rises and the
// config port is always ready; the user must write config only with the
// pipeline empty, which the block itself does not enforce.
// Reset (async, active low) clears the registers to black/white, 1x1 area,
// and empties the pipeline; pixel payload registers are not reset.
// The receiver cannot stall, so nothing in the pipe ever waits.
module diagonal_gradient_dither_rgb565_unit #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [dgd_pkg::PixW-1:0]     pixel_x_i,
  input  logic [dgd_pkg::PixW-1:0]     pixel_y_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dgd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dgd_pkg::ColW-1:0]     cfg_data_i,
  output logic                         valid_o,
  output logic [15:0]                  rgb565_o
);

  dgd_pkg::cfg_t            cfg;
  logic                     accept;
  logic                     bl_valid, dv_valid;
  logic [dgd_pkg::BayW-1:0] bl_bayer, dv_bayer;
  logic [dgd_pkg::NumW-1:0] bl_num [dgd_pkg::NumCh];
  logic [dgd_pkg::QuoW-1:0] dv_quo [dgd_pkg::NumCh];

  // fully pipelined: always takes a pixel, always takes a register write
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  dgd_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // position along the diagonal and blend numerators s*(D-n) + e*n
  dgd_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (accept),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg),
    .valid_o   (bl_valid),
    .bayer_o   (bl_bayer),
    .num_o     (bl_num)
  );

  // floor division by the span gives the 8-bit blended channels
  dgd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bl_valid),
    .bayer_i (bl_bayer),
    .num_i   (bl_num),
    .span_i  (cfg.span),
    .valid_o (dv_valid),
    .bayer_o (dv_bayer),
    .quo_o   (dv_quo)
  );

  // threshold, /8160 via /32 then /255, pack
  dgd_quant u_quant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .bayer_i  (dv_bayer),
    .chan_i   (dv_quo),
    .valid_o  (valid_o),
    .rgb565_o (rgb565_o)
  );

  // every accepted pixel comes out exactly one latency later
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(dgd_pkg::Latency) valid_o)
    else $error("accepted pixel produced no result");

  // no result without a pixel taken one latency before
  a_result_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, dgd_pkg::Latency))
    else $error("result without matching pixel");

endmodule

// ===== verif/dgd_pixel_checker.sv =====
`timescale 1ns / 1ps
// Pixel checker: watches the gradient ditherer's ports, predicts each RGB565 result and compares.
module dgd_pixel_checker #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [dgd_pkg::PixW-1:0]    pixel_x_i,
  input  logic [dgd_pkg::PixW-1:0]    pixel_y_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [dgd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dgd_pkg::ColW-1:0]    cfg_data_i,
  input  logic                        valid_i,
  input  logic [15:0]                 rgb565_i,
  output int unsigned                 mismatch_cnt_o,
  output int unsigned                 pending_o,
  output int unsigned                 compared_o
);

  // Bayer order, entry i in bits 4i+3..4i
  localparam logic [63:0] BayerOrder = 64'h5D7F_91B3_6E4C_A280;

  logic [23:0] grad_start;
  logic [23:0] grad_end;
  logic [10:0] grad_w;
  logic [10:0] grad_h;
  logic [15:0] expected_pixels[$];
  logic [15:0] want;

  function automatic logic [15:0] predict_rgb565(input logic [9:0] px, input logic [9:0] py);
    int unsigned w, h, span, pos, thr, s, e, lvl, top, q, acc;
    int ch;
    w = (grad_w == 0) ? 1 : ((grad_w > MAX_DIM) ? MAX_DIM : grad_w);
    h = (grad_h == 0) ? 1 : ((grad_h > MAX_DIM) ? MAX_DIM : grad_h);
    span = (w + h > 3) ? w + h - 2 : 1;
    pos = px + py;
    if (pos > span) pos = span;
    thr = 32'(BayerOrder[{py[1:0], px[1:0]} * 4 +: 4]);
    acc = 0;
    for (ch = 0; ch < 3; ch++) begin
      s = (grad_start >> (16 - 8 * ch)) & 8'hFF;
      e = (grad_end >> (16 - 8 * ch)) & 8'hFF;
      lvl = (s * (span - pos) + e * pos) / span;
      top = (ch == 1) ? 63 : 31;
      q = (lvl * top * 32 + (2 * thr + 1) * 255) / 8160;
      if (q > top) q = top;
      acc = acc * (top + 1) + q;
    end
    return acc[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grad_start = 24'h000000;
      grad_end = 24'hFFFFFF;
      grad_w = 11'd1;
      grad_h = 11'd1;
      expected_pixels.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
      compared_o = 0;
    end else begin
      // predict before any register update at this edge: the pixel sees the old setting
      if (start_i && !busy_i) begin
        expected_pixels.push_back(predict_rgb565(pixel_x_i, pixel_y_i));
      end
      if (valid_i) begin
        if (expected_pixels.size() == 0) begin
          $error("rgb565: no pixel outstanding, got %h", rgb565_i);
          mismatch_cnt_o++;
        end else begin
          want = expected_pixels.pop_front();
          compared_o++;
          if (rgb565_i !== want) begin
            $error("rgb565 mismatch: expected %h, got %h", want, rgb565_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (dgd_pkg::cfg_reg_e'(cfg_index_i))
          dgd_pkg::RegStartColor: grad_start = cfg_data_i;
          dgd_pkg::RegEndColor:   grad_end = cfg_data_i;
          dgd_pkg::RegAreaWidth:  grad_w = cfg_data_i[10:0];
          dgd_pkg::RegAreaHeight: grad_h = cfg_data_i[10:0];
          default: ;
        endcase
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== verif/tb_diagonal_gradient_dither_rgb565_unit.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, pixel and register stimulus, and the verdict for the ditherer.
module tb_diagonal_gradient_dither_rgb565_unit;

  localparam int unsigned MaxDim      = 1024;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumSegments = 30;
  localparam int unsigned SegPixels   = 52;
  localparam int unsigned DrainCycles = dgd_pkg::Latency + 4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [9:0]  pixel_x_i = '0;
  logic [9:0]  pixel_y_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        valid_o;
  logic [15:0] rgb565_o;

  int unsigned mismatch_cnt;
  int unsigned pending_pixels;
  int unsigned compared_cnt;

  int unsigned cycle_cnt = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_cnt = 0;
  int unsigned idle_pct = 0;
  // effective area, used only to keep most random pixels inside the gradient
  int unsigned area_w = 1;
  int unsigned area_h = 1;

  always #5 clk_i = ~clk_i;

  diagonal_gradient_dither_rgb565_unit #(
    .MAX_DIM(MaxDim)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .rgb565_o    (rgb565_o)
  );

  dgd_pixel_checker #(
    .MAX_DIM(MaxDim)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .valid_i        (valid_o),
    .rgb565_i       (rgb565_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_pixels),
    .compared_o     (compared_cnt)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_diagonal_gradient_dither_rgb565_unit failed");
      $finish;
    end
  end

  // One register transfer. valid is left high so back-to-back writes need no
  // second assignment in the same step; the caller drops it after the batch.
  task automatic write_reg(input dgd_pkg::cfg_reg_e idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Full gradient setting. With garble set, the unused upper data bits of the
  // size writes carry junk, which the block must drop.
  task automatic program_gradient(input logic [23:0] c0, input logic [23:0] c1,
                                  input logic [10:0] w, input logic [10:0] h,
                                  input logic garble);
    logic [12:0] junk_w;
    logic [12:0] junk_h;
    junk_w = garble ? 13'($urandom()) : 13'd0;
    junk_h = garble ? 13'($urandom()) : 13'd0;
    write_reg(dgd_pkg::RegStartColor, c0);
    write_reg(dgd_pkg::RegEndColor, c1);
    write_reg(dgd_pkg::RegAreaWidth, {junk_w, w});
    write_reg(dgd_pkg::RegAreaHeight, {junk_h, h});
    cfg_valid_i <= 1'b0;
    settings_cnt++;
    area_w = (w == 0) ? 1 : ((w > MaxDim) ? MaxDim : w);
    area_h = (h == 0) ? 1 : ((h > MaxDim) ? MaxDim : h);
  endtask

  // One pixel transfer, preceded by a random number of idle cycles. start is
  // only lowered inside a gap, so a back-to-back pixel never sees it toggle.
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  // Stop sending and let every outstanding pixel come out of the pipe, so the
  // registers can be rewritten with nothing in flight.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] c0;
    logic [23:0] c1;
    logic [10:0] w_raw;
    logic [10:0] h_raw;
    logic [9:0]  px;
    logic [9:0]  py;
    int unsigned seg;
    int unsigned i;
    int unsigned pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // reset setting: black to white over a 1x1 area, divisor of one
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);

    // white to black over 4x4: every Bayer cell, then a pixel past the area
    drain();
    program_gradient(24'hFFFFFF, 24'h000000, 11'd4, 11'd4, 1'b0);
    for (i = 0; i < 16; i++) send_pixel(10'(i % 4), 10'(i / 4));
    send_pixel(10'd1023, 10'd1023);

    // zero width read as one, oversized height read as the maximum
    drain();
    program_gradient(24'h0000FF, 24'hFF0000, 11'd0, 11'd2047, 1'b1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd0, 10'd511);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd1023);

    // --- random ---
    // three idle profiles in turn: light sender gaps, heavy gaps, none
    for (seg = 0; seg < NumSegments; seg++) begin
      drain();
      pick = $urandom_range(99);
      if (pick < 15) begin
        c0 = 24'h000000;
        c1 = 24'hFFFFFF;
      end else if (pick < 30) begin
        c0 = 24'hFFFFFF;
        c1 = 24'h000000;
      end else begin
        c0 = 24'($urandom());
        c1 = 24'($urandom());
      end
      case (seg % 8)
        0: begin
          w_raw = 11'd1024;
          h_raw = 11'd1024;
        end
        1: begin
          w_raw = 11'd2047;
          h_raw = 11'd0;
        end
        2: begin
          w_raw = 11'd1;
          h_raw = 11'd1;
        end
        3: begin
          w_raw = 11'($urandom_range(2, 1));
          h_raw = 11'($urandom_range(2, 1));
        end
        7: begin
          w_raw = 11'($urandom_range(2047));
          h_raw = 11'($urandom_range(1024, 1));
        end
        default: begin
          w_raw = 11'($urandom_range(16, 1));
          h_raw = 11'($urandom_range(16, 1));
        end
      endcase
      program_gradient(c0, c1, w_raw, h_raw, 1'($urandom_range(1)));
      idle_pct = (seg < NumSegments / 3) ? 12 : ((seg < 2 * NumSegments / 3) ? 53 : 0);

      for (i = 0; i < SegPixels; i++) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // inside the area, where the blend actually moves
          px = 10'($urandom_range(area_w - 1));
          py = 10'($urandom_range(area_h - 1));
        end else begin
          // anywhere, mostly past the area
          px = 10'($urandom());
          py = 10'($urandom());
        end
        send_pixel(px, py);
      end
    end

    drain();
    $display("Run covered %0d pixel transfers over %0d gradient settings; %0d results compared.",
             pixels_sent, settings_cnt, compared_cnt);
    if (mismatch_cnt == 0 && pending_pixels == 0) begin
      $display("tb_diagonal_gradient_dither_rgb565_unit passed");
    end else begin
      $display("tb_diagonal_gradient_dither_rgb565_unit failed");
    end
    $finish;
  end

endmodule
